// ----- rtl/core/ffba_pkg.sv -----
`default_nettype none
package ffba_pkg;

   localparam int WORD_W = 16;
   localparam int LOG_W  = 4;
   localparam int WIN_W  = 2 * WORD_W;
   localparam int POS_W  = LOG_W;
   localparam int SIZE_W = 4;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef logic [WIN_W-1:0] win_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] pos;
      win_type          mask;
   } fit_type;

endpackage
`default_nettype wire

// ----- rtl/core/ffba_if.sv -----
`default_nettype none
interface ffba_req_if #(
   parameter int ADDR_W = 9
);
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [ffba_pkg::SIZE_W-1:0]  size;
   logic [ADDR_W-1:0]            start_req;

   modport source (output valid, op, size, start_req, input ready);
   modport sink   (input valid, op, size, start_req, output ready);
endinterface

interface ffba_rsp_if #(
   parameter int ADDR_W = 9
);
   logic              valid;
   logic              ready;
   logic              ok;
   logic [ADDR_W-1:0] base;

   modport source (output valid, ok, base, input ready);
   modport sink   (input valid, ok, base, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/first_fit_bitmap_allocator_core.sv -----
`default_nettype none
// First-fit run allocator over a map of MEM_CELLS cells held as 16-bit words in one RAM.
// After reset the map is cleared one word per cycle, with req_chan.ready low. An allocate
// reads the map one word per cycle and checks each word together with the previous one, so
// the length of a scan is set by the single RAM read port; a zero or oversize request goes
// straight to the response. A release reads the start word, clears it and, if the run
// spans into it, the next word; a release that clears nothing goes straight to the response.
// One transaction is worked on at a time, and the result waits in rsp_chan until taken.
module first_fit_bitmap_allocator_core #(
   parameter int MEM_CELLS = 512,
   parameter int MAX_REQ   = 15
) (
   input  wire logic      clock,
   input  wire logic      reset,
   ffba_req_if.sink       req_chan,
   ffba_rsp_if.source     rsp_chan
);
   localparam int ADDR_W     = $clog2(MEM_CELLS);
   localparam int BASE_W     = ADDR_W + 1;
   localparam int W          = ffba_pkg::WORD_W;
   localparam int DEPTH      = (MEM_CELLS + W - 1) / W;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int LAST_VALID = MEM_CELLS - (DEPTH - 1) * W;
   localparam logic [W-1:0]       PAD_MASK = ~((W'(1) << LAST_VALID) - W'(1));
   localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [7:0]         MAX_REQ_L = 8'(MAX_REQ);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SCAN, ST_AWR_LO, ST_REL_RD, ST_REL_LO, ST_REL_HI, ST_RESP
   } state_type;

   state_type                    state_ff, state_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [IDX_W-1:0]             chk_ff, chk_in;
   logic                         pend_ff, pend_in;
   logic [W-1:0]                 prev_ff, prev_in;
   logic [ffba_pkg::SIZE_W-1:0]  need_ff, need_in;
   logic [W-1:0]                 mask_lo_ff, mask_lo_in;
   logic [W-1:0]                 mask_hi_ff, mask_hi_in;
   logic                         hi_en_ff, hi_en_in;
   logic                         ok_ff, ok_in;
   logic [ADDR_W-1:0]            base_ff, base_in;

   logic                         ram_we;
   logic [IDX_W-1:0]             ram_waddr, ram_raddr;
   logic [W-1:0]                 ram_wdata, ram_rdata;
   logic [W-1:0]                 cur_used;
   ffba_pkg::fit_type            fit;
   logic                         accept;
   logic [BASE_W-1:0]            ws_wide, end_addr, start_addr;
   ffba_pkg::win_type            rmask;

   ffba_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ffba_window u_window (
      .win_used ({cur_used, prev_ff}),
      .need     (need_ff),
      .fit      (fit)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = (state_ff == ST_RESP);
   assign rsp_chan.ok    = ok_ff;
   assign rsp_chan.base  = base_ff;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      cur_used   = ram_rdata | ((chk_ff == LAST_IDX) ? PAD_MASK : '0);
      ws_wide    = BASE_W'(req_chan.start_req) >> ffba_pkg::LOG_W;
      rmask      = ((ffba_pkg::WIN_W'(1) << req_chan.size) - ffba_pkg::WIN_W'(1))
                   << req_chan.start_req[ffba_pkg::LOG_W-1:0];
      end_addr   = (BASE_W'(chk_ff) << ffba_pkg::LOG_W) + BASE_W'(fit.pos);
      start_addr = end_addr + BASE_W'(1) - BASE_W'(need_ff);

      state_in   = state_ff;
      cnt_in     = cnt_ff;
      chk_in     = chk_ff;
      pend_in    = pend_ff;
      prev_in    = prev_ff;
      need_in    = need_ff;
      mask_lo_in = mask_lo_ff;
      mask_hi_in = mask_hi_ff;
      hi_en_in   = hi_en_ff;
      ok_in      = ok_ff;
      base_in    = base_ff;

      ram_we     = 1'b0;
      ram_waddr  = chk_ff;
      ram_wdata  = '0;
      ram_raddr  = chk_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff[IDX_W-1:0];
            ram_wdata = '0;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff[IDX_W-1:0] == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               need_in = req_chan.size;
               if (req_chan.op == ffba_pkg::OP_ALLOC) begin
                  if (req_chan.size == '0 || 8'(req_chan.size) > MAX_REQ_L) begin
                     ok_in    = 1'b0;
                     base_in  = '0;
                     state_in = ST_RESP;
                  end else begin
                     cnt_in   = '0;
                     chk_in   = '0;
                     pend_in  = 1'b0;
                     prev_in  = '1;
                     state_in = ST_SCAN;
                  end
               end else begin
                  ok_in      = 1'b1;
                  base_in    = req_chan.start_req;
                  chk_in     = ws_wide[IDX_W-1:0];
                  mask_lo_in = rmask[W-1:0];
                  mask_hi_in = rmask[ffba_pkg::WIN_W-1:W];
                  hi_en_in   = (rmask[ffba_pkg::WIN_W-1:W] != '0)
                               && (ws_wide + BASE_W'(1) < BASE_W'(DEPTH));
                  if (req_chan.size == '0 || ws_wide >= BASE_W'(DEPTH)) begin
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_REL_RD;
                  end
               end
            end
         end
         ST_SCAN: begin
            ram_raddr = cnt_ff[IDX_W-1:0];
            pend_in   = (cnt_ff < CNT_W'(DEPTH));
            if (cnt_ff < CNT_W'(DEPTH)) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               if (fit.found) begin
                  ram_we     = 1'b1;
                  ram_waddr  = chk_ff;
                  ram_wdata  = ram_rdata | fit.mask[ffba_pkg::WIN_W-1:W];
                  mask_lo_in = fit.mask[W-1:0];
                  ok_in      = 1'b1;
                  base_in    = start_addr[ADDR_W-1:0];
                  state_in   = (fit.mask[W-1:0] != '0) ? ST_AWR_LO : ST_RESP;
               end else if (chk_ff == LAST_IDX) begin
                  ok_in    = 1'b0;
                  base_in  = '0;
                  state_in = ST_RESP;
               end else begin
                  prev_in = cur_used;
                  chk_in  = chk_ff + IDX_W'(1);
               end
            end
         end
         ST_AWR_LO: begin
            ram_we    = 1'b1;
            ram_waddr = chk_ff - IDX_W'(1);
            ram_wdata = prev_ff | mask_lo_ff;
            state_in  = ST_RESP;
         end
         ST_REL_RD: begin
            ram_raddr = chk_ff;
            state_in  = ST_REL_LO;
         end
         ST_REL_LO: begin
            ram_we    = 1'b1;
            ram_waddr = chk_ff;
            ram_wdata = ram_rdata & ~mask_lo_ff;
            ram_raddr = chk_ff + IDX_W'(1);
            state_in  = hi_en_ff ? ST_REL_HI : ST_RESP;
         end
         ST_REL_HI: begin
            ram_we    = 1'b1;
            ram_waddr = chk_ff + IDX_W'(1);
            ram_wdata = ram_rdata & ~mask_hi_ff;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
      chk_ff     <= chk_in;
      prev_ff    <= prev_in;
      need_ff    <= need_in;
      mask_lo_ff <= mask_lo_in;
      mask_hi_ff <= mask_hi_in;
      hi_en_ff   <= hi_en_in;
      ok_ff      <= ok_in;
      base_ff    <= base_in;
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request taken while a result is pending");

   a_fail_base: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ok) |-> (rsp_chan.base == '0))
      else $error("failed allocation reports a nonzero base");

   a_zero_alloc: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.op == ffba_pkg::OP_ALLOC && req_chan.size == '0)
      |=> (rsp_chan.valid && !rsp_chan.ok))
      else $error("zero-size allocation not refused at once");

   a_zero_release: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.op == ffba_pkg::OP_RELEASE && req_chan.size == '0)
      |=> (rsp_chan.valid && rsp_chan.ok && rsp_chan.base == $past(req_chan.start_req)))
      else $error("zero-size release result wrong");

   a_alloc_in_map: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ok && state_ff == ST_RESP)
      |-> (BASE_W'(rsp_chan.base) < BASE_W'(MEM_CELLS)
           || $past(state_ff) != ST_SCAN && $past(state_ff) != ST_AWR_LO))
      else $error("allocated base outside the map");
endmodule
`default_nettype wire

// ----- rtl/core/ffba_ram.sv -----
`default_nettype none
module ffba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                                          clock,
   input  wire logic                                          we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
   input  wire logic [WIDTH-1:0]                              wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
   output logic      [WIDTH-1:0]                              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ----- rtl/core/ffba_window.sv -----
`default_nettype none
module ffba_window (
   input  wire ffba_pkg::win_type                win_used,
   input  wire logic [ffba_pkg::SIZE_W-1:0]      need,
   output ffba_pkg::fit_type                     fit
);
   logic [5:0]                     sh;
   ffba_pkg::win_type              base_mask;
   logic [ffba_pkg::WORD_W-1:0]    hit;

   always_comb begin
      sh        = 6'(ffba_pkg::WORD_W + 1) - {2'b00, need};
      base_mask = ((ffba_pkg::WIN_W'(1) << need) - ffba_pkg::WIN_W'(1)) << sh;
      for (int j = 0; j < ffba_pkg::WORD_W; j++) begin
         hit[j] = (need != '0) && ((win_used & (base_mask << j)) == '0);
      end
      fit.found = |hit;
      fit.pos   = '0;
      for (int j = ffba_pkg::WORD_W - 1; j >= 0; j--) begin
         if (hit[j]) begin
            fit.pos = ffba_pkg::POS_W'(j);
         end
      end
      fit.mask = base_mask << fit.pos;
   end
endmodule
`default_nettype wire
